// ===== rtl/tpg_pkg.sv =====
// Shared types, constants and helpers of the text-line paragraph grouper.
`default_nettype none
package tpg_pkg;

    // Coordinate and register widths
    localparam int COORD_WIDTH   = 16;
    localparam int SPACING_WIDTH = 14;
    localparam int TOL_WIDTH     = 10;
    localparam int CFG_WIDTH     = 14;
    localparam int CFG_IDX_WIDTH = 1;

    // Widths of the signed differences used by the line comparisons
    localparam int NEAR_WIDTH = ((COORD_WIDTH > TOL_WIDTH) ? COORD_WIDTH : TOL_WIDTH) + 2;
    localparam int GAP_WIDTH  = ((COORD_WIDTH > SPACING_WIDTH + 1) ?
                                 COORD_WIDTH : SPACING_WIDTH + 1) + 2;

    // Queue depths
    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PTR_WIDTH = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_WIDTH = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PTR_WIDTH = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_WIDTH = $clog2(OUT_DEPTH + 1);
    localparam int MAX_RESULTS   = 3;

    // Register indexes and reset values
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LINE_SPACING = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ALIGN_TOL    = 1'b1;
    localparam logic [SPACING_WIDTH-1:0] SPACING_RESET    = SPACING_WIDTH'(16);
    localparam logic [TOL_WIDTH-1:0]     TOL_RESET        = TOL_WIDTH'(10);

    typedef logic [COORD_WIDTH-1:0] t_coord;

    typedef enum logic [2:0] {
        CODE_NONE   = 3'd0,
        CODE_LEFT   = 3'd1,
        CODE_RIGHT  = 3'd2,
        CODE_CENTER = 3'd3,
        CODE_JUST   = 3'd4
    } t_code;

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
    } t_box;

    typedef struct packed {
        t_coord line_left;
        t_coord line_bottom;
        t_coord line_right;
        t_coord line_top;
        logic   last_line;
    } t_line_item;

    typedef struct packed {
        t_coord para_left;
        t_coord para_bottom;
        t_coord para_right;
        t_coord para_top;
        logic   last_para;
    } t_para_item;

    // Classified line passed from front to back
    typedef struct packed {
        t_box  box;
        t_code code;
        logic  start;
        logic  last;
    } t_cmd;

    function automatic t_box box_union(t_box a, t_box b);
        t_box r;
        r.left   = (a.left   < b.left)   ? a.left   : b.left;
        r.bottom = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        r.right  = (a.right  > b.right)  ? a.right  : b.right;
        r.top    = (a.top    > b.top)    ? a.top    : b.top;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tpg_cmd_fifo.sv =====
// Short queue of classified lines between the front and back parts.
`default_nettype none
module tpg_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tpg_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output tpg_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    tpg_pkg::t_cmd                        r_mem [tpg_pkg::CMD_DEPTH];
    logic [tpg_pkg::CMD_PTR_WIDTH-1:0]    r_wp, r_rp;
    logic [tpg_pkg::CMD_CNT_WIDTH-1:0]    r_cnt, n_cnt;
    logic                                 wr, rd;

    assign o_full  = (r_cnt == tpg_pkg::CMD_CNT_WIDTH'(tpg_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    // Track occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) n_cnt = r_cnt + 1'b1;
        if (!wr && rd) n_cnt = r_cnt - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_cmd;
    end

endmodule
`default_nettype wire

// ===== rtl/tpg_front.sv =====
// Front part: takes line transfers, holds configuration and classifies each line.
`default_nettype none
module tpg_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tpg_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  wire logic [tpg_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                i_push,
    input  wire tpg_pkg::t_line_item                 i_line,
    output logic                                     o_full,
    output logic                                     o_cmd_push,
    output tpg_pkg::t_cmd                            o_cmd,
    input  wire logic                                i_cmd_full
);

    localparam int W  = tpg_pkg::COORD_WIDTH;
    localparam int NW = tpg_pkg::NEAR_WIDTH;
    localparam int GW = tpg_pkg::GAP_WIDTH;

    logic [tpg_pkg::SPACING_WIDTH-1:0] r_spacing;
    logic [tpg_pkg::TOL_WIDTH-1:0]     r_tol;
    tpg_pkg::t_box                     r_prev;
    logic                              r_first;

    tpg_pkg::t_box   cur;
    tpg_pkg::t_code  rel;
    logic            acc, new_block, near_l, near_r, near_m;
    logic [W:0]      sum_c, sum_p;
    logic signed [GW-1:0] gap, gap_lim;

    function automatic logic near(tpg_pkg::t_coord a, tpg_pkg::t_coord b,
                                  logic [tpg_pkg::TOL_WIDTH-1:0] tol);
        logic signed [NW-1:0] d;
        logic signed [NW-1:0] t;
        d = $signed(NW'(a)) - $signed(NW'(b));
        t = $signed(NW'(tol));
        return (d < t) && (d > -t);
    endfunction

    assign o_full     = i_cmd_full;
    assign acc        = i_push && !i_cmd_full;
    assign o_cmd_push = acc;

    // Compare with the previous line
    always_comb begin
        cur.left   = i_line.line_left;
        cur.bottom = i_line.line_bottom;
        cur.right  = i_line.line_right;
        cur.top    = i_line.line_top;
        sum_c  = {1'b0, cur.left} + {1'b0, cur.right};
        sum_p  = {1'b0, r_prev.left} + {1'b0, r_prev.right};
        near_l = near(cur.left, r_prev.left, r_tol);
        near_r = near(cur.right, r_prev.right, r_tol);
        near_m = near(sum_c[W:1], sum_p[W:1], r_tol);
        if (near_l && near_r && near_m)        rel = tpg_pkg::CODE_JUST;
        else if (!near_l && !near_r && near_m) rel = tpg_pkg::CODE_CENTER;
        else if (near_l && !near_r && !near_m) rel = tpg_pkg::CODE_LEFT;
        else if (!near_l && near_r && !near_m) rel = tpg_pkg::CODE_RIGHT;
        else                                   rel = tpg_pkg::CODE_NONE;
        gap       = $signed(GW'(r_prev.bottom)) - $signed(GW'(cur.top));
        gap_lim   = $signed(GW'({r_spacing, 1'b0}));
        new_block = (cur.bottom > r_prev.top) || (gap >= gap_lim);
        o_cmd.box   = cur;
        o_cmd.start = r_first || new_block;
        o_cmd.code  = (r_first || new_block) ? tpg_pkg::CODE_NONE : rel;
        o_cmd.last  = i_line.last_line;
    end

    // Hold configuration and the page position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= tpg_pkg::SPACING_RESET;
            r_tol     <= tpg_pkg::TOL_RESET;
            r_first   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpg_pkg::CFG_LINE_SPACING: r_spacing <= i_cfg_data;
                    tpg_pkg::CFG_ALIGN_TOL:    r_tol <= i_cfg_data[tpg_pkg::TOL_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (acc) r_first <= i_line.last_line;
        end
    end

    // Keep the previous line box
    always_ff @(posedge i_clk) begin
        if (acc) r_prev <= cur;
    end

endmodule
`default_nettype wire

// ===== rtl/tpg_back.sv =====
// Back part: subgroup and paragraph state, and the queue of paragraph results.
`default_nettype none
module tpg_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire tpg_pkg::t_cmd     i_cmd,
    output logic                   o_cmd_pop,
    output logic                   empty,
    output tpg_pkg::t_para_item    o_para,
    input  wire logic              pop
);

    typedef struct packed {
        tpg_pkg::t_box  sub_box;
        logic [1:0]     cnt;
        tpg_pkg::t_code code0;
        tpg_pkg::t_code code1;
        tpg_pkg::t_code run;
        tpg_pkg::t_box  held_box;
        logic           held_v;
        tpg_pkg::t_box  pend_box;
        logic           pend_v;
    } t_bstate;

    typedef struct packed {
        t_bstate       st;
        logic          ev;
        tpg_pkg::t_box eb;
    } t_close_res;

    t_bstate r_st, n_st;

    tpg_pkg::t_para_item                 r_mem [tpg_pkg::OUT_DEPTH];
    logic [tpg_pkg::OUT_PTR_WIDTH-1:0]   r_wp, r_rp;
    logic [tpg_pkg::OUT_CNT_WIDTH-1:0]   r_cnt, n_cnt;

    tpg_pkg::t_para_item cand [tpg_pkg::MAX_RESULTS];
    logic                cand_v [tpg_pkg::MAX_RESULTS];
    tpg_pkg::t_para_item w [tpg_pkg::MAX_RESULTS];
    logic [1:0]          nw;
    logic                exec, rd;
    t_close_res          c1, c2;
    t_bstate             s;
    logic                joins;

    function automatic t_close_res close_sg(t_bstate st, logic has_next);
        t_close_res r;
        r.st = st;
        r.ev = 1'b0;
        r.eb = st.held_box;
        if (st.cnt != 2'd0) begin
            if (st.pend_v) begin
                r.st.pend_v   = 1'b0;
                r.ev          = st.held_v;
                r.st.held_box = tpg_pkg::box_union(st.pend_box, st.sub_box);
                r.st.held_v   = 1'b1;
            end else if (st.cnt == 2'd1 && st.code0 == tpg_pkg::CODE_LEFT) begin
                if (st.held_v) r.st.held_box = tpg_pkg::box_union(st.held_box, st.sub_box);
            end else if (has_next && st.cnt == 2'd2 && st.code0 == tpg_pkg::CODE_NONE &&
                         st.code1 == tpg_pkg::CODE_RIGHT) begin
                r.st.pend_box = st.sub_box;
                r.st.pend_v   = 1'b1;
            end else begin
                r.ev          = st.held_v;
                r.st.held_box = st.sub_box;
                r.st.held_v   = 1'b1;
            end
            r.st.cnt = 2'd0;
        end
        return r;
    endfunction

    function automatic t_bstate start_sg(t_bstate st, tpg_pkg::t_box b, tpg_pkg::t_code c);
        t_bstate r;
        r         = st;
        r.sub_box = b;
        r.cnt     = 2'd1;
        r.code0   = c;
        r.code1   = tpg_pkg::CODE_NONE;
        r.run     = c;
        return r;
    endfunction

    function automatic tpg_pkg::t_para_item to_para(tpg_pkg::t_box b, logic last);
        tpg_pkg::t_para_item p;
        p.para_left   = b.left;
        p.para_bottom = b.bottom;
        p.para_right  = b.right;
        p.para_top    = b.top;
        p.last_para   = last;
        return p;
    endfunction

    // Execute a line only with room for every result it can cause
    assign exec      = i_cmd_valid &&
                       (r_cnt <= tpg_pkg::OUT_CNT_WIDTH'(tpg_pkg::OUT_DEPTH - tpg_pkg::MAX_RESULTS));
    assign o_cmd_pop = exec;
    assign empty     = (r_cnt == '0);
    assign o_para    = r_mem[r_rp];
    assign rd        = pop && !empty;

    // Step the subgroup and paragraph state for one line
    always_comb begin
        s     = r_st;
        c1    = close_sg(r_st, 1'b1);
        c2    = c1;
        joins = ((r_st.run == tpg_pkg::CODE_NONE) && (i_cmd.code != tpg_pkg::CODE_NONE)) ||
                ((r_st.run != tpg_pkg::CODE_NONE) && (i_cmd.code == r_st.run));
        for (int k = 0; k < tpg_pkg::MAX_RESULTS; k++) begin
            cand_v[k] = 1'b0;
            cand[k]   = to_para(r_st.held_box, 1'b0);
        end
        if (i_cmd.start || !joins) begin
            cand_v[0] = c1.ev;
            cand[0]   = to_para(c1.eb, 1'b0);
            s = start_sg(c1.st, i_cmd.box, i_cmd.code);
        end else begin
            s.sub_box = tpg_pkg::box_union(r_st.sub_box, i_cmd.box);
            if (r_st.cnt == 2'd1) s.code1 = i_cmd.code;
            if (r_st.cnt != 2'd3) s.cnt = r_st.cnt + 2'd1;
            s.run = i_cmd.code;
        end
        if (i_cmd.last) begin
            c2        = close_sg(s, 1'b0);
            cand_v[1] = c2.ev;
            cand[1]   = to_para(c2.eb, 1'b0);
            cand_v[2] = c2.st.held_v;
            cand[2]   = to_para(c2.st.held_box, 1'b1);
            s         = c2.st;
            s.cnt     = 2'd0;
            s.held_v  = 1'b0;
            s.pend_v  = 1'b0;
            s.code0   = tpg_pkg::CODE_NONE;
            s.code1   = tpg_pkg::CODE_NONE;
            s.run     = tpg_pkg::CODE_NONE;
        end
        n_st = exec ? s : r_st;
    end

    // Pack the results in order
    always_comb begin
        nw = 2'd0;
        for (int k = 0; k < tpg_pkg::MAX_RESULTS; k++) w[k] = cand[k];
        if (exec) begin
            for (int k = 0; k < tpg_pkg::MAX_RESULTS; k++) begin
                if (cand_v[k]) begin
                    w[nw] = cand[k];
                    nw    = nw + 2'd1;
                end
            end
        end
        n_cnt = r_cnt + tpg_pkg::OUT_CNT_WIDTH'(nw) - tpg_pkg::OUT_CNT_WIDTH'(rd);
    end

    // Hold state and queue pointers
    always_ff @(posedge i_clk) begin
        r_st.sub_box  <= n_st.sub_box;
        r_st.held_box <= n_st.held_box;
        r_st.pend_box <= n_st.pend_box;
        if (!i_rst_n) begin
            r_st.cnt    <= 2'd0;
            r_st.code0  <= tpg_pkg::CODE_NONE;
            r_st.code1  <= tpg_pkg::CODE_NONE;
            r_st.run    <= tpg_pkg::CODE_NONE;
            r_st.held_v <= 1'b0;
            r_st.pend_v <= 1'b0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_cnt       <= '0;
        end else begin
            r_st.cnt    <= n_st.cnt;
            r_st.code0  <= n_st.code0;
            r_st.code1  <= n_st.code1;
            r_st.run    <= n_st.run;
            r_st.held_v <= n_st.held_v;
            r_st.pend_v <= n_st.pend_v;
            r_wp        <= r_wp + tpg_pkg::OUT_PTR_WIDTH'(nw);
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt       <= n_cnt;
        end
    end

    // Store results
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < tpg_pkg::MAX_RESULTS; k++) begin
            if (k < int'(nw)) r_mem[r_wp + tpg_pkg::OUT_PTR_WIDTH'(k)] <= w[k];
        end
    end

    // The result queue never overruns
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tpg_pkg::OUT_CNT_WIDTH'(tpg_pkg::OUT_DEPTH))
        else $error("result queue overrun");

    // A final line leaves a clean page
    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_cmd.last) |=> (!r_st.held_v && !r_st.pend_v && r_st.cnt == 2'd0))
        else $error("page state left after final line");

    // Any other line leaves a subgroup open
    a_sub_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && !i_cmd.last) |=> (r_st.cnt != 2'd0))
        else $error("no open subgroup after a line");

endmodule
`default_nettype wire

// ===== rtl/textline_paragraph_grouper_unit.sv =====
// Top level of the text-line paragraph grouper.
// Line boxes go in at one per clock while the two-entry line queue has room; the front
// classifies each line in the cycle of its transfer and the back applies it to the subgroup
// and paragraph state from the line queue, one line per clock while the four-entry
// result queue has at least three free places. A result is written to the result queue
// when the back applies the line that completes it. One paragraph is held back until a later
// line decides it, so results lag the lines; a line with last_line set flushes the page.
`default_nettype none
module textline_paragraph_grouper_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [tpg_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire logic [tpg_pkg::CFG_WIDTH-1:0]     i_cfg_data,
    input  wire logic                              push,
    input  wire tpg_pkg::t_line_item               i_line,
    output logic                                   full,
    output logic                                   empty,
    output tpg_pkg::t_para_item                    o_para,
    input  wire logic                              pop
);

    logic          cmd_push, cmd_full, cmd_valid, cmd_pop;
    tpg_pkg::t_cmd cmd_in, cmd_out;

    // Classify lines
    tpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_line     (i_line),
        .o_full     (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // Decouple front and back
    tpg_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_out),
        .i_pop   (cmd_pop)
    );

    // Group into paragraphs
    tpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .o_para      (o_para),
        .pop         (pop)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the text-line paragraph grouper: lines in, paragraph boxes out.
`default_nettype none
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tpg_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx = '0;
    logic [tpg_pkg::CFG_WIDTH-1:0] i_cfg_data = '0;
    logic push = 1'b0;
    tpg_pkg::t_line_item i_line = '0;
    logic pop = 1'b0;
    logic full, empty;
    tpg_pkg::t_para_item o_para;

    textline_paragraph_grouper_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .push(push), .i_line(i_line), .full(full),
        .empty(empty), .o_para(o_para), .pop(pop)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    logic [tpg_pkg::SPACING_WIDTH-1:0] spacing_q;
    logic [tpg_pkg::TOL_WIDTH-1:0] tol_q;
    tpg_pkg::t_box prev_box, sub_box, held_box, merge_box;
    int unsigned sub_count;
    tpg_pkg::t_code sub_code0, sub_code1, sub_running;
    bit first_line, held_ok, merge_ok;

    tpg_pkg::t_line_item line_queue[$];
    tpg_pkg::t_para_item para_expected[$];
    int errors = 0;
    int paras_seen = 0;
    int lines_sent = 0;
    longint cycle_count = 0;
    bit hold_off = 1'b0;

    function automatic bit is_near(tpg_pkg::t_coord cur, tpg_pkg::t_coord prv);
        int d;
        d = int'(cur) - int'(prv);
        return (d < int'(tol_q)) && (d > -int'(tol_q));
    endfunction

    function automatic tpg_pkg::t_code line_code(tpg_pkg::t_box c, tpg_pkg::t_box p);
        bit l, r, m;
        tpg_pkg::t_coord cm, pm;
        cm = tpg_pkg::t_coord'(({1'b0, c.left} + {1'b0, c.right}) >> 1);
        pm = tpg_pkg::t_coord'(({1'b0, p.left} + {1'b0, p.right}) >> 1);
        l = is_near(c.left, p.left);
        r = is_near(c.right, p.right);
        m = is_near(cm, pm);
        if (l && r && m) return tpg_pkg::CODE_JUST;
        if (!l && !r && m) return tpg_pkg::CODE_CENTER;
        if (l && !r && !m) return tpg_pkg::CODE_LEFT;
        if (!l && r && !m) return tpg_pkg::CODE_RIGHT;
        return tpg_pkg::CODE_NONE;
    endfunction

    function automatic tpg_pkg::t_box merge_boxes(tpg_pkg::t_box a, tpg_pkg::t_box b);
        tpg_pkg::t_box r;
        r.left = (a.left < b.left) ? a.left : b.left;
        r.bottom = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        r.right = (a.right > b.right) ? a.right : b.right;
        r.top = (a.top > b.top) ? a.top : b.top;
        return r;
    endfunction

    function automatic void push_para(tpg_pkg::t_box b, bit last);
        tpg_pkg::t_para_item p;
        p.para_left = b.left;
        p.para_bottom = b.bottom;
        p.para_right = b.right;
        p.para_top = b.top;
        p.last_para = last;
        para_expected.push_back(p);
    endfunction

    function automatic void open_para(tpg_pkg::t_box b);
        if (held_ok) push_para(held_box, 1'b0);
        held_box = b;
        held_ok = 1'b1;
    endfunction

    function automatic void close_sub(bit has_next);
        if (sub_count == 0) return;
        if (merge_ok) begin
            merge_ok = 1'b0;
            open_para(merge_boxes(merge_box, sub_box));
        end else if (sub_count == 1 && sub_code0 == tpg_pkg::CODE_LEFT) begin
            if (held_ok) held_box = merge_boxes(held_box, sub_box);
        end else if (has_next && sub_count == 2 && sub_code0 == tpg_pkg::CODE_NONE &&
                     sub_code1 == tpg_pkg::CODE_RIGHT) begin
            merge_box = sub_box;
            merge_ok = 1'b1;
        end else begin
            open_para(sub_box);
        end
        sub_count = 0;
    endfunction

    function automatic void open_sub(tpg_pkg::t_box b, tpg_pkg::t_code c);
        sub_box = b;
        sub_count = 1;
        sub_code0 = c;
        sub_code1 = tpg_pkg::CODE_NONE;
        sub_running = c;
    endfunction

    function automatic void clear_page();
        prev_box = '0;
        sub_box = '0;
        sub_count = 0;
        sub_code0 = tpg_pkg::CODE_NONE;
        sub_code1 = tpg_pkg::CODE_NONE;
        sub_running = tpg_pkg::CODE_NONE;
        held_box = '0;
        merge_box = '0;
        first_line = 1'b1;
        held_ok = 1'b0;
        merge_ok = 1'b0;
    endfunction

    // Work out the paragraphs that one accepted line releases
    function automatic void predict_paras(tpg_pkg::t_line_item it);
        tpg_pkg::t_box cur;
        int gap;
        bit fresh, joins;
        tpg_pkg::t_code c;
        cur.left = it.line_left;
        cur.bottom = it.line_bottom;
        cur.right = it.line_right;
        cur.top = it.line_top;
        if (first_line) begin
            open_sub(cur, tpg_pkg::CODE_NONE);
            first_line = 1'b0;
        end else begin
            gap = int'(prev_box.bottom) - int'(cur.top);
            fresh = (cur.bottom > prev_box.top) || (gap >= 2 * int'(spacing_q));
            if (fresh) begin
                close_sub(1'b1);
                open_sub(cur, tpg_pkg::CODE_NONE);
            end else begin
                c = line_code(cur, prev_box);
                joins = (sub_running == tpg_pkg::CODE_NONE && c != tpg_pkg::CODE_NONE) ||
                        (sub_running != tpg_pkg::CODE_NONE && c == sub_running);
                if (joins) begin
                    sub_box = merge_boxes(sub_box, cur);
                    if (sub_count == 1) sub_code1 = c;
                    if (sub_count < 3) sub_count++;
                    sub_running = c;
                end else begin
                    close_sub(1'b1);
                    open_sub(cur, c);
                end
            end
        end
        prev_box = cur;
        if (it.last_line) begin
            close_sub(1'b0);
            if (held_ok) push_para(held_box, 1'b1);
            clear_page();
        end
    endfunction

    // Driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && push && !full) begin
            predict_paras(i_line);
            lines_sent <= lines_sent + 1;
        end
        if (i_rst_n && (!push || !full)) begin
            if (push && !full) void'(line_queue.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if (line_queue.size() > 0) begin
                push <= 1'b1;
                i_line <= line_queue[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: random pop stalls, compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        tpg_pkg::t_para_item want;
        if (i_rst_n && pop && !empty) begin
            paras_seen <= paras_seen + 1;
            if (para_expected.size() == 0) begin
                $display("%0t: unexpected paragraph %h", $time, o_para);
                errors <= errors + 1;
            end else begin
                want = para_expected.pop_front();
                if (want !== o_para) begin
                    $display("%0t: paragraph mismatch expected %h actual %h",
                             $time, want, o_para);
                    errors <= errors + 1;
                end
            end
        end
        if (hold_off) pop <= 1'b0;
        else if (cycle_count % 64 < 20) pop <= 1'b1;
        else pop <= ($urandom_range(0, 3) != 0);
    end

    // Long receiver hold-off, counted here
    initial begin
        int n;
        wait (lines_sent > 150);
        hold_off = 1'b1;
        for (n = 0; n < 300; n++) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("textline_paragraph_grouper_unit test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [tpg_pkg::CFG_IDX_WIDTH-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= tpg_pkg::CFG_WIDTH'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tpg_pkg::CFG_LINE_SPACING) spacing_q = tpg_pkg::SPACING_WIDTH'(value);
        else tol_q = tpg_pkg::TOL_WIDTH'(value);
    endtask

    task automatic wait_idle();
        int n;
        while (line_queue.size() != 0 || push || para_expected.size() != 0)
            @(posedge i_clk);
        for (n = 0; n < DRAIN_CYCLES; n++) @(posedge i_clk);
    endtask

    function automatic tpg_pkg::t_line_item make_line(int l, int b, int r, int t, bit last);
        tpg_pkg::t_line_item it;
        it.line_left = tpg_pkg::t_coord'(l);
        it.line_bottom = tpg_pkg::t_coord'(b);
        it.line_right = tpg_pkg::t_coord'(r);
        it.line_top = tpg_pkg::t_coord'(t);
        it.last_line = last;
        return it;
    endfunction

    // Queue a page of lines running down the page, mostly well-formed
    task automatic queue_page(int lines);
        int y, x, w, h, k, style, l, r;
        y = $urandom_range(2000, 65000);
        x = $urandom_range(0, 3000);
        w = $urandom_range(200, 2000);
        for (k = 0; k < lines; k++) begin
            h = $urandom_range(10, 30);
            style = $urandom_range(0, 9);
            l = x; r = x + w;
            case (style)
                0: r = x + w - $urandom_range(20, 400);
                1: l = x + $urandom_range(20, 400);
                2: begin l = x + 50; r = x + w - 50; end
                3: begin l = $urandom_range(0, 65535); r = $urandom_range(0, 65535); end
                default: begin
                    l = x + $urandom_range(0, 12);
                    r = x + w - $urandom_range(0, 12);
                end
            endcase
            if ($urandom_range(0, 15) == 0) y = y - $urandom_range(40, 300);
            if ($urandom_range(0, 30) == 0) y = $urandom_range(0, 65535);
            if (y < h + 2) y = h + 2 + $urandom_range(0, 60000);
            line_queue.push_back(make_line(l, y - h, r, y, k == lines - 1));
            y = y - h - $urandom_range(0, 8);
        end
    endtask

    initial begin
        int phase, k;
        clear_page();
        spacing_q = tpg_pkg::SPACING_RESET;
        tol_q = tpg_pkg::TOL_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone line, extremes, each alignment, right-then-merge, left joiner
        line_queue.push_back(make_line(100, 900, 500, 920, 1'b1));
        line_queue.push_back(make_line(0, 0, 0, 0, 1'b0));
        line_queue.push_back(make_line(65535, 65535, 65535, 65535, 1'b1));
        line_queue.push_back(make_line(100, 980, 900, 1000, 1'b0));
        line_queue.push_back(make_line(100, 958, 900, 978, 1'b0));
        line_queue.push_back(make_line(100, 936, 900, 956, 1'b0));
        line_queue.push_back(make_line(100, 914, 600, 934, 1'b0));
        line_queue.push_back(make_line(400, 892, 600, 912, 1'b0));
        line_queue.push_back(make_line(300, 870, 700, 890, 1'b0));
        line_queue.push_back(make_line(200, 848, 800, 868, 1'b0));
        line_queue.push_back(make_line(700, 826, 800, 846, 1'b0));
        line_queue.push_back(make_line(100, 804, 900, 824, 1'b0));
        line_queue.push_back(make_line(100, 700, 300, 720, 1'b0));
        line_queue.push_back(make_line(100, 678, 300, 698, 1'b0));
        line_queue.push_back(make_line(105, 600, 900, 620, 1'b0));
        line_queue.push_back(make_line(100, 3000, 900, 3020, 1'b0));
        line_queue.push_back(make_line(0, 100, 65535, 200, 1'b1));
        wait_idle();

        // Random phases across register settings, extremes included
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(tpg_pkg::CFG_LINE_SPACING, 0);
                    write_reg(tpg_pkg::CFG_ALIGN_TOL, 0);
                end
                1: begin
                    write_reg(tpg_pkg::CFG_LINE_SPACING, 16383);
                    write_reg(tpg_pkg::CFG_ALIGN_TOL, 1023);
                end
                2: begin
                    write_reg(tpg_pkg::CFG_LINE_SPACING, 16);
                    write_reg(tpg_pkg::CFG_ALIGN_TOL, 10);
                end
                default: begin
                    write_reg(tpg_pkg::CFG_LINE_SPACING, $urandom_range(0, 100));
                    write_reg(tpg_pkg::CFG_ALIGN_TOL, $urandom_range(1, 40));
                end
            endcase
            for (k = 0; k < 16; k++) queue_page($urandom_range(1, 9));
            wait_idle();
        end

        $display("%0d lines sent, %0d paragraphs checked over six register settings",
                 lines_sent, paras_seen);
        $display("with alignment mixes, block breaks, page flushes and a long output stall");
        if (errors == 0) $display("textline_paragraph_grouper_unit test passed");
        else $display("textline_paragraph_grouper_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/tpg_pkg.sv
rtl/tpg_cmd_fifo.sv
rtl/tpg_front.sv
rtl/tpg_back.sv
rtl/textline_paragraph_grouper_unit.sv
tb/tb_top.sv
